// ===== sv/scpg_pkg.sv =====
// Package for the six-channel servo pulse generator.
// Holds the input and result word types and the fixed field widths; no dependencies.
package scpg_pkg;

    localparam int unsigned WIDTH_FIELD_W = 8;
    localparam int unsigned NUM_WIDTHS    = 6;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam int unsigned CH_FRONT = 0;
    localparam int unsigned CH_REAR  = 1;
    localparam int unsigned CH_LEFT  = 2;
    localparam int unsigned CH_RIGHT = 3;
    localparam int unsigned CH_ROLL  = 4;
    localparam int unsigned CH_TILT  = 5;

    typedef struct packed {
        logic                     kind;
        logic [WIDTH_FIELD_W-1:0] front_width;
        logic [WIDTH_FIELD_W-1:0] rear_width;
        logic [WIDTH_FIELD_W-1:0] left_width;
        logic [WIDTH_FIELD_W-1:0] right_width;
        logic [WIDTH_FIELD_W-1:0] roll_width;
        logic [WIDTH_FIELD_W-1:0] tilt_width;
    } in_word_t;

    typedef struct packed {
        logic front_level;
        logic rear_level;
        logic left_level;
        logic right_level;
        logic roll_level;
        logic tilt_level;
        logic busy_res;
        logic start_refused;
    } out_word_t;

endpackage

// ===== sv/scpg_levels.sv =====
// Output level decode for the servo pulse generator.
// Compares the frame tick against each channel's pulse end; uses scpg_pkg.
module scpg_levels #(
    parameter int unsigned PHASE_TICKS = 256,
    parameter int unsigned WIDTH_BITS  = 8,
    parameter int unsigned TICK_W      = 10,
    parameter int unsigned KEEP_W      = 8
) (
    input  logic [TICK_W-1:0]                           tick,
    input  logic                                        active,
    input  logic [scpg_pkg::NUM_WIDTHS-1:0][KEEP_W-1:0] widths,
    input  logic                                        cam_enable,
    input  logic                                        refused,
    output scpg_pkg::out_word_t                         levels
);

    localparam int unsigned END_MAX = 2 * PHASE_TICKS + (2 ** WIDTH_BITS);
    localparam int unsigned END_W   = $clog2(END_MAX + 1);
    localparam int unsigned CMP_W   = (END_W > TICK_W) ? END_W : TICK_W;

    localparam logic [CMP_W-1:0] FULL_WIDTH = CMP_W'(2 ** WIDTH_BITS);
    localparam logic [CMP_W-1:0] PHASE_1    = CMP_W'(PHASE_TICKS);
    localparam logic [CMP_W-1:0] PHASE_2    = CMP_W'(2 * PHASE_TICKS);

    logic [CMP_W-1:0]                          t_ext;
    logic [scpg_pkg::NUM_WIDTHS-1:0][CMP_W-1:0] eff;
    logic [scpg_pkg::NUM_WIDTHS-1:0]           on;

    assign t_ext = CMP_W'(tick);

    always_comb begin
        for (int i = 0; i < scpg_pkg::NUM_WIDTHS; i++) begin
            eff[i] = (widths[i] == '0) ? FULL_WIDTH : CMP_W'(widths[i]);
        end
        for (int i = 0; i < 4; i++) begin
            on[i] = t_ext < (PHASE_1 + eff[i]);
        end
        for (int i = 4; i < scpg_pkg::NUM_WIDTHS; i++) begin
            on[i] = cam_enable && (t_ext >= PHASE_1) && (t_ext < (PHASE_2 + eff[i]));
        end
    end

    always_comb begin
        levels.front_level   = active && on[scpg_pkg::CH_FRONT];
        levels.rear_level    = active && on[scpg_pkg::CH_REAR];
        levels.left_level    = active && on[scpg_pkg::CH_LEFT];
        levels.right_level   = active && on[scpg_pkg::CH_RIGHT];
        levels.roll_level    = active && on[scpg_pkg::CH_ROLL];
        levels.tilt_level    = active && on[scpg_pkg::CH_TILT];
        levels.busy_res      = active;
        levels.start_refused = refused;
    end

endmodule

// ===== sv/six_channel_servo_pulse_generator_top.sv =====
// Top level of the six-channel servo pulse generator.
// Holds frame state, the camera enable register and the result register; uses scpg_pkg
// and scpg_levels.
//
// Every accepted input word yields one result word, registered and offered in the cycle
// after acceptance; a new word is accepted in every cycle in which the result register
// is empty or being drained, so the sustained rate is one word per clock. A start word
// latches six widths and opens a frame of three times PHASE_TICKS ticks; each tick word
// advances the frame by one. Motor outputs are high from tick 0 to PHASE_TICKS plus the
// width, camera outputs, when the camera enable is set, from PHASE_TICKS to twice
// PHASE_TICKS plus the width, and a width of zero means two to the power WIDTH_BITS. A
// start word during a running frame is refused and flagged in its result.
module six_channel_servo_pulse_generator_top #(
    parameter int unsigned PHASE_TICKS = 256,
    parameter int unsigned WIDTH_BITS  = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scpg_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output scpg_pkg::out_word_t m_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);

    localparam int unsigned FRAME_TICKS = 3 * PHASE_TICKS;
    localparam int unsigned TICK_W      = $clog2(FRAME_TICKS);
    localparam int unsigned KEEP_W      = (WIDTH_BITS < scpg_pkg::WIDTH_FIELD_W) ?
                                          WIDTH_BITS : scpg_pkg::WIDTH_FIELD_W;
    localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(FRAME_TICKS - 1);

    logic [TICK_W-1:0]                           tick_reg, tick_next;
    logic                                        active_reg, active_next;
    logic [scpg_pkg::NUM_WIDTHS-1:0][KEEP_W-1:0] widths_reg, widths_next;
    logic                                        cam_enable_reg;
    logic                                        m_valid_reg;
    scpg_pkg::out_word_t                         m_data_reg;
    scpg_pkg::out_word_t                         levels;
    logic                                        refused;
    logic                                        accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        tick_next   = tick_reg;
        active_next = active_reg;
        widths_next = widths_reg;
        refused     = 1'b0;
        if (s_data.kind == scpg_pkg::KIND_START) begin
            if (active_reg) begin
                refused = 1'b1;
            end else begin
                widths_next[scpg_pkg::CH_FRONT] = s_data.front_width[KEEP_W-1:0];
                widths_next[scpg_pkg::CH_REAR]  = s_data.rear_width[KEEP_W-1:0];
                widths_next[scpg_pkg::CH_LEFT]  = s_data.left_width[KEEP_W-1:0];
                widths_next[scpg_pkg::CH_RIGHT] = s_data.right_width[KEEP_W-1:0];
                widths_next[scpg_pkg::CH_ROLL]  = s_data.roll_width[KEEP_W-1:0];
                widths_next[scpg_pkg::CH_TILT]  = s_data.tilt_width[KEEP_W-1:0];
                tick_next   = '0;
                active_next = 1'b1;
            end
        end else if (active_reg) begin
            if (tick_reg == LAST_TICK) begin
                tick_next   = '0;
                active_next = 1'b0;
            end else begin
                tick_next = tick_reg + TICK_W'(1);
            end
        end
    end

    scpg_levels #(
        .PHASE_TICKS(PHASE_TICKS),
        .WIDTH_BITS (WIDTH_BITS),
        .TICK_W     (TICK_W),
        .KEEP_W     (KEEP_W)
    ) u_levels (
        .tick      (tick_next),
        .active    (active_next),
        .widths    (widths_next),
        .cam_enable(cam_enable_reg),
        .refused   (refused),
        .levels    (levels)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            active_reg     <= 1'b0;
            widths_reg     <= '0;
            cam_enable_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cam_enable_reg <= cfg_wr_data;
            end
            if (accept) begin
                tick_reg    <= tick_next;
                active_reg  <= active_next;
                widths_reg  <= widths_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= levels;
        end
    end

endmodule
